// ----- rtl/sorted_table_search_defines.svh -----
`ifndef SORTED_TABLE_SEARCH_DEFINES_SVH
`define SORTED_TABLE_SEARCH_DEFINES_SVH

// Same-cycle implication, checked on the rising clock edge outside of reset.
`define STS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on the rising clock edge outside of reset.
`define STS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/sts_pkg.sv -----
package sts_pkg;

	localparam int DEPTH_DEF       = 1024;
	localparam int VALUE_WIDTH_DEF = 32;

	// One register, so a single index bit above the word offset is enough.
	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;
	localparam logic [CFG_ADDR_W-3:0] REG_ENTRY_COUNT = '0;

	typedef enum logic [2:0] {
		OP_WRITE   = 3'd0,
		OP_FIND    = 3'd1,
		OP_LOWER   = 3'd2,
		OP_UPPER   = 3'd3,
		OP_NEAREST = 3'd4
	} opcode_t;

	// Control that travels along the cell chain with each search.
	typedef struct packed {
		logic    valid;
		logic    pending;
		opcode_t op;
	} sts_ctrl_t;

endpackage

// ----- rtl/sts_query_if.sv -----
interface sts_query_if #(
	parameter int IDX_W = 10,
	parameter int VW    = 32
);
	logic                 valid;
	logic                 ready;
	logic [2:0]           opcode;
	logic [IDX_W-1:0]     entry_index;
	logic signed [VW-1:0] key;

	modport source (output valid, opcode, entry_index, key, input ready);
	modport sink (input valid, opcode, entry_index, key, output ready);
endinterface

// ----- rtl/sts_result_if.sv -----
interface sts_result_if #(
	parameter int POS_W = 11
);
	logic             valid;
	logic             ready;
	logic [POS_W-1:0] position;
	logic             found;

	modport source (output valid, position, found, input ready);
	modport sink (input valid, position, found, output ready);
endinterface

// ----- rtl/sorted_table_search.sv -----
// Binary search engine over a table of up to DEPTH signed entries kept in ascending
// order. Write beats (opcode write) load one entry and are taken one per cycle while
// no search is in flight; beats with an unknown opcode are taken and dropped. A search
// beat runs down a chain of $clog2(DEPTH+1)+1 probe cells, one table read per cycle
// from the single read port of the entry memory, then a finishing stage and the
// output register. No new beat is taken until the search has left the finishing
// stage for the output register. A result left waiting there does not hold up the
// next query, but its search then waits in the finishing stage until the result is
// taken. entry_count is written over the APB port while idle, which the user must
// keep to as the block does not enforce it; values above DEPTH act as DEPTH, and
// reading an entry that was never written gives an unspecified value.
module sorted_table_search #(
	parameter int DEPTH       = sts_pkg::DEPTH_DEF,
	parameter int VALUE_WIDTH = sts_pkg::VALUE_WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	sts_query_if.sink                        query,
	sts_result_if.source                     result,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [sts_pkg::CFG_ADDR_W-1:0]   paddr,
	input  logic [sts_pkg::CFG_DATA_W-1:0]   pwdata,
	output logic [sts_pkg::CFG_DATA_W-1:0]   prdata,
	output logic                             pready
);
	import sts_pkg::*;

	localparam int VW    = VALUE_WIDTH;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int POS_W = $clog2(DEPTH + 1);
	localparam int NCELL = POS_W + 1;
	localparam logic [POS_W-1:0] DEPTH_POS = POS_W'(DEPTH);
	localparam logic [IDX_W:0]   DEPTH_IDX = (IDX_W + 1)'(DEPTH);

	logic [POS_W-1:0] entry_count_q;
	logic [POS_W-1:0] used_count;
	logic             cfg_write;
	logic             reg_hit;

	logic             q_accept;
	opcode_t          op_in;
	logic             is_search;
	logic             is_write;
	logic             busy;
	logic             result_busy;

	logic [VW-1:0]    mem [DEPTH];
	logic [VW-1:0]    rdata_q;
	logic [IDX_W-1:0] rd_addr;

	sts_ctrl_t            c_ctrl  [NCELL+1];
	logic signed [VW-1:0] c_key   [NCELL+1];
	logic [POS_W-1:0]     c_n     [NCELL+1];
	logic [POS_W-1:0]     c_first [NCELL+1];
	logic [POS_W-1:0]     c_count [NCELL+1];
	logic signed [VW-1:0] c_below [NCELL+1];
	logic signed [VW-1:0] c_above [NCELL+1];
	logic                 c_rd_en [NCELL];
	logic [IDX_W-1:0]     c_addr  [NCELL];

	// Configuration port.
	assign pready    = 1'b1;
	assign reg_hit   = (paddr[CFG_ADDR_W-1:2] == REG_ENTRY_COUNT);
	assign cfg_write = psel && penable && pwrite && reg_hit;
	assign prdata    = reg_hit ? CFG_DATA_W'(entry_count_q) : '0;
	assign used_count = (entry_count_q > DEPTH_POS) ? DEPTH_POS : entry_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg_write) begin
			entry_count_q <= pwdata[POS_W-1:0];
		end
	end

	// Query intake.
	always_comb begin
		op_in     = opcode_t'(query.opcode);
		is_search = op_in inside {OP_FIND, OP_LOWER, OP_UPPER, OP_NEAREST};
		is_write  = (op_in == OP_WRITE);
	end

	always_comb begin
		busy = result_busy;
		for (int i = 1; i <= NCELL; i++) begin
			busy = busy | c_ctrl[i].valid;
		end
	end

	assign query.ready = !busy;
	assign q_accept    = query.valid && query.ready;

	assign c_ctrl[0].valid   = q_accept && is_search;
	assign c_ctrl[0].pending = 1'b0;
	assign c_ctrl[0].op      = op_in;
	assign c_key[0]          = query.key;
	assign c_n[0]            = used_count;
	assign c_first[0]        = '0;
	assign c_count[0]        = used_count;
	assign c_below[0]        = '0;
	assign c_above[0]        = '0;

	// Entry memory: one write port for loads, one registered read port for probes.
	always_ff @(posedge clk) begin
		if (q_accept && is_write && ({1'b0, query.entry_index} < DEPTH_IDX)) begin
			mem[query.entry_index] <= query.key;
		end
	end

	// Only one cell issues a probe in any cycle.
	always_comb begin
		rd_addr = '0;
		for (int i = 0; i < NCELL; i++) begin
			rd_addr = rd_addr | (c_addr[i] & {IDX_W{c_rd_en[i]}});
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem[rd_addr];
	end

	for (genvar g = 0; g < NCELL; g++) begin : g_cell
		sts_cell #(
			.VW    (VW),
			.PW    (POS_W),
			.IDX_W (IDX_W)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctrl_in   (c_ctrl[g]),
			.key_in    (c_key[g]),
			.n_in      (c_n[g]),
			.first_in  (c_first[g]),
			.count_in  (c_count[g]),
			.below_in  (c_below[g]),
			.above_in  (c_above[g]),
			.rdata     (rdata_q),
			.ctrl_out  (c_ctrl[g+1]),
			.key_out   (c_key[g+1]),
			.n_out     (c_n[g+1]),
			.first_out (c_first[g+1]),
			.count_out (c_count[g+1]),
			.below_out (c_below[g+1]),
			.above_out (c_above[g+1]),
			.rd_en     (c_rd_en[g]),
			.rd_addr   (c_addr[g])
		);
	end

	sts_result #(
		.VW (VW),
		.PW (POS_W)
	) u_result (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl_in  (c_ctrl[NCELL]),
		.key_in   (c_key[NCELL]),
		.n_in     (c_n[NCELL]),
		.first_in (c_first[NCELL]),
		.below_in (c_below[NCELL]),
		.above_in (c_above[NCELL]),
		.busy     (result_busy),
		.res      (result)
	);

endmodule

// ----- rtl/sts_cell.sv -----
module sts_cell #(
	parameter int VW    = 32,
	parameter int PW    = 11,
	parameter int IDX_W = 10
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sts_pkg::sts_ctrl_t   ctrl_in,
	input  logic signed [VW-1:0] key_in,
	input  logic [PW-1:0]        n_in,
	input  logic [PW-1:0]        first_in,
	input  logic [PW-1:0]        count_in,
	input  logic signed [VW-1:0] below_in,
	input  logic signed [VW-1:0] above_in,
	input  logic signed [VW-1:0] rdata,
	output sts_pkg::sts_ctrl_t   ctrl_out,
	output logic signed [VW-1:0] key_out,
	output logic [PW-1:0]        n_out,
	output logic [PW-1:0]        first_out,
	output logic [PW-1:0]        count_out,
	output logic signed [VW-1:0] below_out,
	output logic signed [VW-1:0] above_out,
	output logic                 rd_en,
	output logic [IDX_W-1:0]     rd_addr
);
	import sts_pkg::*;

	sts_ctrl_t            ctrl_q;
	logic signed [VW-1:0] key_q;
	logic [PW-1:0]        n_q;
	logic [PW-1:0]        first_q;
	logic [PW-1:0]        count_q;
	logic signed [VW-1:0] below_q;
	logic signed [VW-1:0] above_q;

	logic [PW-1:0] step;
	logic [PW-1:0] probe;
	logic          go_right;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
		end else begin
			ctrl_q <= ctrl_in;
		end
	end

	always_ff @(posedge clk) begin
		key_q   <= key_in;
		n_q     <= n_in;
		first_q <= first_in;
		count_q <= count_in;
		below_q <= below_in;
		above_q <= above_in;
	end

	// The entry probed by the previous cell arrives on rdata in this cycle.
	// below holds the entry just left of the window, above the one just right of it.
	always_comb begin
		step      = count_q >> 1;
		go_right  = (ctrl_q.op == OP_UPPER) ? (rdata <= key_q) : (rdata < key_q);
		key_out   = key_q;
		n_out     = n_q;
		first_out = first_q;
		count_out = count_q;
		below_out = below_q;
		above_out = above_q;
		if (ctrl_q.pending) begin
			if (go_right) begin
				first_out = first_q + step + PW'(1);
				count_out = count_q - step - PW'(1);
				below_out = rdata;
			end else begin
				count_out = step;
				above_out = rdata;
			end
		end
		ctrl_out         = ctrl_q;
		ctrl_out.pending = ctrl_q.valid && (count_out != '0);
		rd_en            = ctrl_out.pending;
		probe            = first_out + (count_out >> 1);
		rd_addr          = probe[IDX_W-1:0];
	end

endmodule

// ----- rtl/sts_result.sv -----
module sts_result #(
	parameter int VW = 32,
	parameter int PW = 11
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sts_pkg::sts_ctrl_t   ctrl_in,
	input  logic signed [VW-1:0] key_in,
	input  logic [PW-1:0]        n_in,
	input  logic [PW-1:0]        first_in,
	input  logic signed [VW-1:0] below_in,
	input  logic signed [VW-1:0] above_in,
	output logic                 busy,
	sts_result_if.source         res
);
	import sts_pkg::*;

	logic                 valid_s1;
	opcode_t              op_s1;
	logic signed [VW-1:0] key_s1;
	logic [PW-1:0]        n_s1;
	logic [PW-1:0]        first_s1;
	logic signed [VW-1:0] below_s1;
	logic signed [VW-1:0] above_s1;

	logic          out_valid_q;
	logic [PW-1:0] position_q;
	logic          found_q;

	logic          out_load;
	logic [VW:0]   dist_below;
	logic [VW:0]   dist_above;
	logic [PW-1:0] position_d;
	logic          found_d;

	assign out_load = valid_s1 && (!out_valid_q || res.ready);
	assign busy     = valid_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctrl_in.valid) begin
				valid_s1 <= 1'b1;
			end else if (out_load) begin
				valid_s1 <= 1'b0;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl_in.valid) begin
			op_s1    <= ctrl_in.op;
			key_s1   <= key_in;
			n_s1     <= n_in;
			first_s1 <= first_in;
			below_s1 <= below_in;
			above_s1 <= above_in;
		end
		if (out_load) begin
			position_q <= position_d;
			found_q    <= found_d;
		end
	end

	// Distances are one bit wider than the values and compared unsigned, so a
	// negative distance from an out-of-order table ranks above any true one.
	always_comb begin
		dist_below = {key_s1[VW-1], key_s1} - {below_s1[VW-1], below_s1};
		dist_above = {above_s1[VW-1], above_s1} - {key_s1[VW-1], key_s1};
		position_d = first_s1;
		found_d    = 1'b1;
		case (op_s1)
			OP_FIND: begin
				found_d    = (first_s1 < n_s1) && (above_s1 == key_s1);
				position_d = found_d ? first_s1 : '0;
			end
			OP_NEAREST: begin
				if (first_s1 == '0) begin
					position_d = '0;
				end else if (first_s1 == n_s1) begin
					position_d = n_s1 - PW'(1);
				end else if (dist_below <= dist_above) begin
					position_d = first_s1 - PW'(1);
				end else begin
					position_d = first_s1;
				end
			end
			default: begin
				position_d = first_s1;
			end
		endcase
	end

	assign res.valid    = out_valid_q;
	assign res.position = position_q;
	assign res.found    = found_q;

endmodule

// ----- rtl/sts_checker.sv -----
`include "sorted_table_search_defines.svh"

module sts_checker #(
	parameter int POS_W = 11
) (
	input logic             clk,
	input logic             arst_n,
	input logic             q_valid,
	input logic             q_ready,
	input logic [2:0]       q_opcode,
	input logic             r_valid,
	input logic             r_ready,
	input logic [POS_W-1:0] r_position,
	input logic             r_found
);
	import sts_pkg::*;

	`STS_ASSERT_NEXT(a_result_hold, clk, arst_n, r_valid && !r_ready, r_valid && $stable(r_position) && $stable(r_found), "result beat changed while stalled")

	`STS_ASSERT_NOW(a_miss_at_zero, clk, arst_n, r_valid && !r_found, r_position == '0, "missed find must report position zero")

	`STS_ASSERT_NEXT(a_search_blocks, clk, arst_n, q_valid && q_ready && (q_opcode == OP_FIND || q_opcode == OP_LOWER || q_opcode == OP_UPPER || q_opcode == OP_NEAREST), !q_ready && !$rose(r_valid), "search beat did not occupy the engine")

	`STS_ASSERT_NEXT(a_write_free, clk, arst_n, q_valid && q_ready && q_opcode == OP_WRITE, q_ready, "write beat blocked the next beat")

endmodule

bind sorted_table_search sts_checker #(
	.POS_W (POS_W)
) u_sts_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.q_valid    (query.valid),
	.q_ready    (query.ready),
	.q_opcode   (query.opcode),
	.r_valid    (result.valid),
	.r_ready    (result.ready),
	.r_position (result.position),
	.r_found    (result.found)
);
